/* rtl/core/qos_request_aggregator_unit_defines.svh */
// Assertion macros shared by the request aggregator RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef QOS_REQUEST_AGGREGATOR_UNIT_DEFINES_SVH
`define QOS_REQUEST_AGGREGATOR_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Checked outside reset only
`define QRA_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("qra assertion failed");
// Checked at every edge, reset included
`define QRA_ASSERT_RST(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("qra reset assertion failed");
`else
`define QRA_ASSERT(label, clk, rst_n, prop)
`define QRA_ASSERT_RST(label, clk, prop)
`endif

`endif

/* rtl/core/qra_pkg.sv */
// Package for the QoS request aggregator: sizes, codes, state type.
// No dependencies; imported by every module of the block.
package qra_pkg;

    localparam int NUM_SLOTS   = 16;
    localparam int SLOT_IDX_W  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CNT_W       = $clog2(NUM_SLOTS + 1);

    localparam int CMD_W       = 2;
    localparam int SLOT_W      = 4;
    localparam int CLASS_W     = 3;
    localparam int VALUE_W     = 32;
    localparam int STATUS_W    = 2;

    localparam logic [VALUE_W-1:0] VALUE_ALL_ONES = 32'hFFFF_FFFF;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD    = 2'd0,
        CMD_UPDATE = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_QUERY  = 2'd3
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_BAD_CLASS = 2'd1,
        ST_NOT_FOUND = 2'd2
    } t_status;

    localparam logic [CLASS_W-1:0] CLS_MIN_PERF     = 3'd0;
    localparam logic [CLASS_W-1:0] CLS_MAX_PERF     = 3'd1;
    localparam logic [CLASS_W-1:0] CLS_CPU_LATENCY  = 3'd2;
    localparam logic [CLASS_W-1:0] CLS_NO_DEEP_IDLE = 3'd3;
    localparam logic [CLASS_W-1:0] CLS_THERMAL      = 3'd4;
    localparam logic [CLASS_W-1:0] CLASS_MAX_LEGAL  = CLS_THERMAL;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RM_READ,
        S_RM_CHECK,
        S_SCAN,
        S_SCAN_LAST,
        S_FINISH
    } t_state;

    // Operands of the shared compare unit
    typedef struct packed {
        logic               takes_max;
        logic [CLASS_W-1:0] cls;
        logic               ent_valid;
        logic [CLASS_W-1:0] ent_cls;
        logic [VALUE_W-1:0] ent_value;
        logic [VALUE_W-1:0] acc;
    } t_cmp_req;

    // Classes that aggregate to the largest request
    function automatic logic class_takes_max(input logic [CLASS_W-1:0] cls);
        return (cls == CLS_MIN_PERF) || (cls == CLS_NO_DEEP_IDLE) ||
               (cls == CLS_THERMAL);
    endfunction

endpackage

/* rtl/core/qra_cmp_unit.sv */
// Shared slot compare unit: class match plus max/min value select.
// Depends on qra_pkg.
module qra_cmp_unit (
    input  qra_pkg::t_cmp_req               i_req,
    output logic                            o_hit,
    output logic [qra_pkg::VALUE_W-1:0]     o_acc_next
);
    import qra_pkg::*;

    logic w_better;

    // Entry counts only if valid and of the requested class
    assign o_hit = i_req.ent_valid && (i_req.ent_cls == i_req.cls);

    // One 32-bit magnitude compare, direction set by the class
    always_comb begin
        if (i_req.takes_max) begin
            w_better = i_req.ent_value > i_req.acc;
        end else begin
            w_better = i_req.ent_value < i_req.acc;
        end
    end

    assign o_acc_next = (o_hit && w_better) ? i_req.ent_value : i_req.acc;

endmodule

/* rtl/core/qos_request_aggregator_unit.sv */
// Top level of the QoS request aggregator: slot table, sequencer, result register.
// Depends on qra_pkg, qra_cmp_unit and qos_request_aggregator_unit_defines.svh.
//
// Usage:
//   Input channel i_valid / o_stall carries one command transaction (add,
//   update, remove, query) with slot, class and value. Output channel
//   o_valid / i_stall returns one status / effective value per command.
//   Add and update write the slot table in the accept cycle; their result
//   passes through S_FINISH to the output register. Remove reads the slot
//   (one registered read) in S_RM_READ and checks it in S_RM_CHECK. Query
//   walks the table one slot per cycle through the shared compare unit and
//   takes the last entry in S_SCAN_LAST before S_FINISH.
//   One command is in flight at a time; o_stall is high until the result
//   has moved to the output register, so the sequencer sets the rate.
//   The output register holds a finished result while i_stall is high, and
//   the next command may be accepted meanwhile; its result waits in the
//   sequencer until the output register frees up.
//   Reset (synchronous, active low) clears all slot valid marks and the
//   output valid flag; the table contents need no clearing.
`include "qos_request_aggregator_unit_defines.svh"

module qos_request_aggregator_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic [qra_pkg::CMD_W-1:0]        i_command,
    input  logic [qra_pkg::SLOT_W-1:0]       i_request_slot,
    input  logic [qra_pkg::CLASS_W-1:0]      i_request_class,
    input  logic [qra_pkg::VALUE_W-1:0]      i_request_value,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic [qra_pkg::STATUS_W-1:0]     o_status,
    output logic [qra_pkg::VALUE_W-1:0]      o_effective_value
);
    import qra_pkg::*;

    // Sequencer and command registers
    t_state                  r_state, n_state;
    logic [SLOT_IDX_W-1:0]   r_slot;
    logic                    r_in_range;
    logic [CLASS_W-1:0]      r_class;
    logic                    r_takes_max;
    logic                    r_is_query;
    logic [CNT_W-1:0]        r_cnt;
    logic                    r_dv;
    logic [SLOT_IDX_W-1:0]   r_didx;
    logic [VALUE_W-1:0]      r_acc;
    t_status                 r_res_status;
    logic [VALUE_W-1:0]      r_res_value;

    // Slot table: valid marks in flops, class and value in memory
    logic [NUM_SLOTS-1:0]    r_slot_valid;
    logic [CLASS_W-1:0]      r_mem_class [NUM_SLOTS];
    logic [VALUE_W-1:0]      r_mem_value [NUM_SLOTS];
    logic [CLASS_W-1:0]      r_rd_class;
    logic [VALUE_W-1:0]      r_rd_value;

    // Output register
    logic                    r_out_valid;
    t_status                 r_out_status;
    logic [VALUE_W-1:0]      r_out_value;

    // Control signals
    logic                    w_accept;
    logic                    w_cls_ok;
    logic                    w_in_range;
    logic [SLOT_IDX_W-1:0]   w_slot_idx;
    t_cmd                    w_cmd;
    logic                    w_out_free;
    logic [SLOT_IDX_W-1:0]   w_rd_addr;
    logic                    w_we_class;
    logic                    w_we_value;
    logic                    w_valid_clr;
    logic                    w_load_out;
    logic                    w_last_issue;

    // Compare unit
    t_cmp_req                w_cmp_req;
    logic                    w_hit;
    logic [VALUE_W-1:0]      w_acc_next;

    // Input decode
    assign w_accept     = i_valid && !o_stall;
    assign w_cls_ok     = i_request_class <= CLASS_MAX_LEGAL;
    assign w_in_range   = 32'(i_request_slot) < 32'(NUM_SLOTS);
    assign w_slot_idx   = SLOT_IDX_W'(i_request_slot);
    assign w_cmd        = t_cmd'(i_command);
    assign w_out_free   = !r_out_valid || !i_stall;
    assign w_last_issue = r_cnt == CNT_W'(NUM_SLOTS - 1);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if (!w_cls_ok) begin
                        n_state = S_FINISH;
                    end else begin
                        unique case (w_cmd)
                            CMD_ADD, CMD_UPDATE: n_state = S_FINISH;
                            CMD_REMOVE:          n_state = S_RM_READ;
                            CMD_QUERY:           n_state = S_SCAN;
                            default:             n_state = S_FINISH;
                        endcase
                    end
                end
            end
            S_RM_READ:   n_state = S_RM_CHECK;
            S_RM_CHECK:  n_state = S_FINISH;
            S_SCAN: begin
                if (w_last_issue) begin
                    n_state = S_SCAN_LAST;
                end
            end
            S_SCAN_LAST: n_state = S_FINISH;
            S_FINISH: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:     n_state = S_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        o_stall     = 1'b1;
        w_rd_addr   = r_slot;
        w_we_class  = 1'b0;
        w_we_value  = 1'b0;
        w_valid_clr = 1'b0;
        w_load_out  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_stall    = 1'b0;
                w_we_class = i_valid && w_cls_ok && w_in_range && (w_cmd == CMD_ADD);
                w_we_value = i_valid && w_cls_ok && w_in_range &&
                             ((w_cmd == CMD_ADD) || (w_cmd == CMD_UPDATE));
            end
            S_RM_READ:   w_rd_addr = r_slot;
            S_RM_CHECK:  w_valid_clr = r_in_range && w_hit;
            S_SCAN:      w_rd_addr = r_cnt[SLOT_IDX_W-1:0];
            S_SCAN_LAST: w_rd_addr = r_slot;
            S_FINISH:    w_load_out = w_out_free;
            default:     o_stall = 1'b1;
        endcase
    end

    // Slot memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_we_class) begin
            r_mem_class[w_slot_idx] <= i_request_class;
        end
        if (w_we_value) begin
            r_mem_value[w_slot_idx] <= i_request_value;
        end
        r_rd_class <= r_mem_class[w_rd_addr];
        r_rd_value <= r_mem_value[w_rd_addr];
    end

    // Shared compare unit over the entry just read
    always_comb begin
        w_cmp_req.takes_max = r_takes_max;
        w_cmp_req.cls       = r_class;
        w_cmp_req.ent_valid = r_slot_valid[r_didx];
        w_cmp_req.ent_cls   = r_rd_class;
        w_cmp_req.ent_value = r_rd_value;
        w_cmp_req.acc       = r_acc;
    end

    qra_cmp_unit u_cmp (
        .i_req      (w_cmp_req),
        .o_hit      (w_hit),
        .o_acc_next (w_acc_next)
    );

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_slot_valid <= '0;
            r_out_valid  <= 1'b0;
            r_cnt        <= '0;
            r_dv         <= 1'b0;
        end else begin
            r_state <= n_state;
            r_dv    <= r_state == S_SCAN;
            if (w_accept) begin
                r_cnt <= '0;
            end else if (r_state == S_SCAN) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end
            if (w_we_class) begin
                r_slot_valid[w_slot_idx] <= 1'b1;
            end else if (w_valid_clr) begin
                r_slot_valid[r_didx] <= 1'b0;
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Command, accumulator and result payload
    always_ff @(posedge i_clk) begin
        r_didx <= w_rd_addr;
        if (w_accept) begin
            r_slot       <= w_slot_idx;
            r_in_range   <= w_in_range;
            r_class      <= i_request_class;
            r_takes_max  <= class_takes_max(i_request_class);
            r_is_query   <= w_cmd == CMD_QUERY;
            r_acc        <= class_takes_max(i_request_class) ? '0 : VALUE_ALL_ONES;
            r_res_status <= w_cls_ok ? ST_OK : ST_BAD_CLASS;
            r_res_value  <= '0;
        end else if (r_dv) begin
            r_acc <= w_acc_next;
        end
        if (r_state == S_RM_CHECK) begin
            r_res_status <= (r_in_range && w_hit) ? ST_OK : ST_NOT_FOUND;
        end
        if (r_state == S_SCAN_LAST) begin
            r_res_value <= w_acc_next;
        end
        if (w_load_out) begin
            r_out_status <= r_res_status;
            r_out_value  <= r_res_value;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_status          = r_out_status;
    assign o_effective_value = r_out_value;

    // Assertions
    `QRA_ASSERT_RST(a_rst_clears, i_clk, !i_rst_n |=> (r_state == S_IDLE) && !o_valid)
    `QRA_ASSERT(a_accept_blocks, i_clk, i_rst_n, w_accept |=> o_stall)
    `QRA_ASSERT(a_rm_order, i_clk, i_rst_n, (r_state == S_RM_CHECK) |-> ($past(r_state) == S_RM_READ))
    `QRA_ASSERT(a_scan_bound, i_clk, i_rst_n, (r_state == S_SCAN) |-> (32'(r_cnt) < 32'(NUM_SLOTS)))
    `QRA_ASSERT(a_nonquery_zero, i_clk, i_rst_n, ((r_state == S_FINISH) && !r_is_query) |-> (r_res_value == '0))

endmodule
